// ===== hw/rtl/credit_fifo_job_dispatcher_macros.svh =====
// Assertion macros for the job dispatcher checker.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef CREDIT_FIFO_JOB_DISPATCHER_MACROS_SVH
`define CREDIT_FIFO_JOB_DISPATCHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFJD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CFJD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cfjd_pkg.sv =====
// Shared types, constants and helpers of the job dispatcher.
// No dependencies.
package cfjd_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_CREDITS = 16;
	localparam int ID_BITS     = 32;
	localparam int CRED_W      = 5;
	localparam int CNT_W       = 5;
	localparam int USED_W      = $clog2(MAX_CREDITS * MAX_CREDITS + 1);

	localparam logic [CRED_W-1:0] TOTAL_RESET = CRED_W'(4);
	localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(16);

	localparam logic [1:0] OP_SUBMIT   = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_COMPLETE = 2'd2;
	localparam logic [1:0] OP_SHUTDOWN = 2'd3;

	localparam logic [1:0] OUT_SUCCEEDED = 2'd0;
	localparam logic [1:0] OUT_CANCELLED = 2'd2;

	localparam logic [3:0] EV_QUEUED     = 4'd0;
	localparam logic [3:0] EV_STARTING   = 4'd1;
	localparam logic [3:0] EV_CANCELLED  = 4'd2;
	localparam logic [3:0] EV_CANCELLING = 4'd3;
	localparam logic [3:0] EV_SUCCEEDED  = 4'd4;
	localparam logic [3:0] EV_FAILED     = 4'd5;
	localparam logic [3:0] EV_FULL       = 4'd6;
	localparam logic [3:0] EV_SHUTTING   = 4'd7;
	localparam logic [3:0] EV_NOT_FOUND  = 4'd8;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [CRED_W-1:0]  cred;
	} job_t;

	typedef struct packed {
		logic load;
		logic shift;
	} wcell_ctl_t;

	typedef struct packed {
		logic load;
		logic set_cancel;
		logic clear;
	} rcell_ctl_t;

	typedef struct packed {
		logic valid;
		logic cancel;
		job_t job;
	} rcell_st_t;

	typedef struct packed {
		logic [3:0]         ev;
		logic [ID_BITS-1:0] ref_id;
		logic [CRED_W-1:0]  cred;
		logic [CNT_W-1:0]   pos;
		logic [CRED_W-1:0]  free;
	} res_t;

	function automatic logic [CRED_W-1:0] eff_total(input logic [CRED_W-1:0] v);
		logic [CRED_W-1:0] r;
		r = v;
		if (v == '0) r = CRED_W'(1);
		else if (v > CRED_W'(MAX_CREDITS)) r = CRED_W'(MAX_CREDITS);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) r = CNT_W'(1);
		else if (v > CNT_W'(QUEUE_DEPTH)) r = CNT_W'(QUEUE_DEPTH);
		return r;
	endfunction

endpackage

// ===== hw/rtl/cfjd_wait_cell.sv =====
// One place of the wait queue: holds a job, takes its right neighbor on shift.
// Depends on cfjd_pkg.
module cfjd_wait_cell (
	input  logic              clk,
	input  cfjd_pkg::wcell_ctl_t ctl,
	input  cfjd_pkg::job_t    load_job,
	input  cfjd_pkg::job_t    next_job,
	input  logic [cfjd_pkg::ID_BITS-1:0] key,
	input  logic              live,
	input  logic              hit_in,
	output cfjd_pkg::job_t    job,
	output logic              hit_here,
	output logic              hit_out
);
	import cfjd_pkg::*;

	job_t job_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			job_q <= load_job;
		end else if (ctl.shift) begin
			job_q <= next_job;
		end
	end

	// first match along the row wins
	assign hit_here = !hit_in && live && (job_q.id == key);
	assign hit_out  = hit_in || hit_here;
	assign job      = job_q;

endmodule

// ===== hw/rtl/cfjd_run_cell.sv =====
// One running slot: job, valid and cancel flags; chained match and free search.
// Depends on cfjd_pkg.
module cfjd_run_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  cfjd_pkg::rcell_ctl_t ctl,
	input  cfjd_pkg::job_t    load_job,
	input  logic [cfjd_pkg::ID_BITS-1:0] key,
	input  logic              hit_in,
	input  logic              free_in,
	output cfjd_pkg::rcell_st_t st,
	output logic              hit_here,
	output logic              hit_out,
	output logic              free_here,
	output logic              free_out
);
	import cfjd_pkg::*;

	logic valid_q;
	logic cancel_q;
	job_t job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			cancel_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q  <= 1'b1;
			cancel_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q  <= 1'b0;
			cancel_q <= 1'b0;
		end else if (ctl.set_cancel) begin
			cancel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			job_q <= load_job;
		end
	end

	assign hit_here  = !hit_in && valid_q && (job_q.id == key);
	assign hit_out   = hit_in || hit_here;
	assign free_here = !free_in && !valid_q;
	assign free_out  = free_in || free_here;
	assign st        = '{valid: valid_q, cancel: cancel_q, job: job_q};

endmodule

// ===== hw/rtl/credit_fifo_job_dispatcher.sv =====
// Top level of the credit FIFO job dispatcher: sequencer, config port, cell rows.
// Depends on cfjd_pkg, cfjd_wait_cell, cfjd_run_cell.
//
// Channel   Handshake              Payload
// command   start / busy           op, job_id, requested_credits, outcome
// result    res_valid (strobe)     event_res, job_ref, granted_credits,
//                                  wait_rank, free_credits, last
// config    APB psel/penable/...   paddr, pwdata, prdata
//
// A command is taken when start is high and busy low; busy stays high until
// the cycle that shows the final result (last=1). A rejected submit, a cancel
// that finds no waiting job, a completion that finds no running job and a
// shutdown with nothing to drain return straight to idle, the last silently.
// Other commands, among them completions that free credits, pass through the
// dispatch or shutdown state, stepping the head of the wait-cell row once a
// cycle. Results come one per cycle with no gaps; the receiver cannot
// stall. Reset is asynchronous: queue empty, no running jobs, pool 4, next id 1.
module credit_fifo_job_dispatcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] job_id,
	input  logic [7:0]  requested_credits,
	input  logic [1:0]  outcome,
	output logic        res_valid,
	output logic [3:0]  event_res,
	output logic [31:0] job_ref,
	output logic [4:0]  granted_credits,
	output logic [4:0]  wait_rank,
	output logic [4:0]  free_credits,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cfjd_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DISP, ST_SHUT} state_t;

	state_t state_q;

	// latched command
	logic [1:0]         op_q;
	logic [ID_BITS-1:0] key_q;
	logic [7:0]         req_q;
	logic [1:0]         outc_q;

	// scheduler state
	logic [CNT_W-1:0]   count_q;
	logic [CRED_W-1:0]  free_q;
	logic [USED_W-1:0]  used_q;
	logic [ID_BITS-1:0] next_id_q;
	logic               closing_q;
	logic [CRED_W-1:0]  total_q;
	logic [CNT_W-1:0]   limit_q;

	// one result held back until we know whether another follows
	res_t pend_q;
	logic pend_v_q;
	res_t out_q;
	logic res_valid_q;
	logic last_q;

	// cell rows
	wcell_ctl_t wctl [QUEUE_DEPTH];
	job_t       wjob [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] w_here;
	logic [QUEUE_DEPTH-1:0] w_out;
	logic [QUEUE_DEPTH-1:0] w_live;

	rcell_ctl_t rctl [MAX_CREDITS];
	rcell_st_t  rst_c [MAX_CREDITS];
	logic [MAX_CREDITS-1:0] r_here;
	logic [MAX_CREDITS-1:0] r_out;
	logic [MAX_CREDITS-1:0] f_here;
	logic [MAX_CREDITS-1:0] f_out;

	logic              w_any, r_any, f_any;
	logic [CRED_W-1:0] w_sel_cred;
	logic [CRED_W-1:0] r_sel_cred;
	logic              r_sel_cancel;
	job_t              head;
	job_t              new_job;
	logic [CRED_W-1:0] tot_eff;
	logic [CRED_W-1:0] clamp_c;
	logic              full;
	logic              can_disp;
	logic [CRED_W:0]   comp_sum;
	logic [CRED_W-1:0] comp_free;
	logic [3:0]        comp_ev;
	logic              cfg_wr;
	logic [CRED_W-1:0] wr_total;
	logic [CRED_W-1:0] cfg_free;

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_wait
			assign w_live[g] = count_q > CNT_W'(g);
			cfjd_wait_cell u_cell (
				.clk      (clk),
				.ctl      (wctl[g]),
				.load_job (new_job),
				.next_job ((g == QUEUE_DEPTH - 1) ? job_t'('0) : wjob[(g + 1) % QUEUE_DEPTH]),
				.key      (key_q),
				.live     (w_live[g]),
				.hit_in   ((g == 0) ? 1'b0 : w_out[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
				.job      (wjob[g]),
				.hit_here (w_here[g]),
				.hit_out  (w_out[g])
			);
		end
		for (g = 0; g < MAX_CREDITS; g++) begin : g_run
			cfjd_run_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (rctl[g]),
				.load_job  (head),
				.key       (key_q),
				.hit_in    ((g == 0) ? 1'b0 : r_out[(g + MAX_CREDITS - 1) % MAX_CREDITS]),
				.free_in   ((g == 0) ? 1'b0 : f_out[(g + MAX_CREDITS - 1) % MAX_CREDITS]),
				.st        (rst_c[g]),
				.hit_here  (r_here[g]),
				.hit_out   (r_out[g]),
				.free_here (f_here[g]),
				.free_out  (f_out[g])
			);
		end
	endgenerate

	assign w_any = w_out[QUEUE_DEPTH-1];
	assign r_any = r_out[MAX_CREDITS-1];
	assign f_any = f_out[MAX_CREDITS-1];
	assign head  = wjob[0];

	// fields of the matched cells (at most one hit per row)
	always_comb begin
		w_sel_cred   = '0;
		r_sel_cred   = '0;
		r_sel_cancel = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (w_here[i]) w_sel_cred = w_sel_cred | wjob[i].cred;
		end
		for (int i = 0; i < MAX_CREDITS; i++) begin
			if (r_here[i]) begin
				r_sel_cred   = r_sel_cred | rst_c[i].job.cred;
				r_sel_cancel = r_sel_cancel | rst_c[i].cancel;
			end
		end
	end

	// submit clamp and queue checks
	assign tot_eff = eff_total(total_q);
	always_comb begin
		if (req_q == 8'd0) clamp_c = CRED_W'(1);
		else if (req_q > {3'b000, tot_eff}) clamp_c = tot_eff;
		else clamp_c = req_q[CRED_W-1:0];
	end
	assign full    = (count_q >= eff_limit(limit_q)) || (count_q >= CNT_W'(QUEUE_DEPTH));
	assign new_job = '{id: next_id_q, cred: clamp_c};

	assign can_disp = !closing_q && (count_q != '0) && (head.cred <= free_q) && f_any;

	// completion: return credits, saturate at the pool size
	assign comp_sum  = {1'b0, free_q} + {1'b0, r_sel_cred};
	assign comp_free = (comp_sum > {1'b0, tot_eff}) ? tot_eff : comp_sum[CRED_W-1:0];
	always_comb begin
		if (outc_q == OUT_SUCCEEDED) comp_ev = r_sel_cancel ? EV_CANCELLED : EV_SUCCEEDED;
		else if (outc_q == OUT_CANCELLED) comp_ev = EV_CANCELLED;
		else comp_ev = EV_FAILED;
	end

	// pool resize: what is not held by running jobs
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign wr_total = eff_total(pwdata[CRED_W-1:0]);
	assign cfg_free = (used_q >= USED_W'(wr_total)) ? '0
		: CRED_W'(USED_W'(wr_total) - used_q);

	// cell commands
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) wctl[i] = '0;
		for (int i = 0; i < MAX_CREDITS; i++) rctl[i] = '0;
		unique case (state_q)
			ST_EXEC: begin
				case (op_q)
					OP_SUBMIT: begin
						if (!closing_q && !full) begin
							for (int i = 0; i < QUEUE_DEPTH; i++)
								wctl[i].load = (count_q == CNT_W'(i));
						end
					end
					OP_CANCEL: begin
						if (w_any) begin
							for (int i = 0; i < QUEUE_DEPTH; i++) wctl[i].shift = w_out[i];
						end else begin
							for (int i = 0; i < MAX_CREDITS; i++) rctl[i].set_cancel = r_here[i];
						end
					end
					OP_COMPLETE: begin
						for (int i = 0; i < MAX_CREDITS; i++) rctl[i].clear = r_here[i];
					end
					default: ;
				endcase
			end
			ST_DISP: begin
				if (can_disp) begin
					for (int i = 0; i < QUEUE_DEPTH; i++) wctl[i].shift = 1'b1;
					for (int i = 0; i < MAX_CREDITS; i++) rctl[i].load = f_here[i];
				end
			end
			ST_SHUT: begin
				if (count_q != '0) begin
					for (int i = 0; i < QUEUE_DEPTH; i++) wctl[i].shift = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			last_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			count_q     <= '0;
			free_q      <= eff_total(TOTAL_RESET);
			used_q      <= '0;
			next_id_q   <= ID_BITS'(1);
			closing_q   <= 1'b0;
			total_q     <= TOTAL_RESET;
			limit_q     <= LIMIT_RESET;
		end else begin
			res_valid_q <= 1'b0;
			last_q      <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= op;
						key_q   <= job_id;
						req_q   <= requested_credits;
						outc_q  <= outcome;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q)
						OP_SUBMIT: begin
							if (closing_q || full) begin
								out_q       <= '{ev: closing_q ? EV_SHUTTING : EV_FULL,
									ref_id: '0, cred: clamp_c, pos: '0, free: free_q};
								res_valid_q <= 1'b1;
								last_q      <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								next_id_q <= next_id_q + ID_BITS'(1);
								count_q   <= count_q + CNT_W'(1);
								pend_q    <= '{ev: EV_QUEUED, ref_id: next_id_q, cred: clamp_c,
									pos: count_q + CNT_W'(1), free: free_q};
								pend_v_q  <= 1'b1;
								state_q   <= ST_DISP;
							end
						end
						OP_CANCEL: begin
							if (w_any) begin
								count_q  <= count_q - CNT_W'(1);
								pend_q   <= '{ev: EV_CANCELLED, ref_id: key_q, cred: w_sel_cred,
									pos: '0, free: free_q};
								pend_v_q <= 1'b1;
								state_q  <= ST_DISP;
							end else begin
								out_q       <= '{ev: r_any ? EV_CANCELLING : EV_NOT_FOUND,
									ref_id: key_q, cred: r_sel_cred, pos: '0, free: free_q};
								res_valid_q <= 1'b1;
								last_q      <= 1'b1;
								state_q     <= ST_IDLE;
							end
						end
						OP_COMPLETE: begin
							if (r_any) begin
								free_q   <= comp_free;
								used_q   <= used_q - USED_W'(r_sel_cred);
								pend_q   <= '{ev: comp_ev, ref_id: key_q, cred: r_sel_cred,
									pos: '0, free: comp_free};
								pend_v_q <= 1'b1;
								state_q  <= ST_DISP;
							end else begin
								out_q       <= '{ev: EV_NOT_FOUND, ref_id: key_q, cred: '0,
									pos: '0, free: free_q};
								res_valid_q <= 1'b1;
								last_q      <= 1'b1;
								state_q     <= ST_IDLE;
							end
						end
						default: begin
							// shutdown: drain the queue once, later ones are silent
							if (!closing_q && count_q != '0) begin
								state_q <= ST_SHUT;
							end else begin
								state_q <= ST_IDLE;
							end
							closing_q <= 1'b1;
						end
					endcase
				end
				ST_DISP: begin
					res_valid_q <= 1'b1;
					out_q       <= pend_q;
					if (can_disp) begin
						free_q  <= free_q - head.cred;
						used_q  <= used_q + USED_W'(head.cred);
						count_q <= count_q - CNT_W'(1);
						pend_q  <= '{ev: EV_STARTING, ref_id: head.id, cred: head.cred,
							pos: '0, free: free_q - head.cred};
					end else begin
						last_q   <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_SHUT: begin
					if (count_q != '0) begin
						res_valid_q <= pend_v_q;
						out_q       <= pend_q;
						count_q     <= count_q - CNT_W'(1);
						pend_q      <= '{ev: EV_CANCELLED, ref_id: head.id, cred: head.cred,
							pos: '0, free: free_q};
						pend_v_q    <= 1'b1;
					end else begin
						res_valid_q <= 1'b1;
						out_q       <= pend_q;
						last_q      <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// config writes are to arrive only while idle; the block itself does not enforce it
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_TOTAL: begin
						total_q <= pwdata[CRED_W-1:0];
						free_q  <= cfg_free;
					end
					REG_LIMIT: limit_q <= pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign res_valid       = res_valid_q;
	assign event_res       = out_q.ev;
	assign job_ref         = out_q.ref_id;
	assign granted_credits = out_q.cred;
	assign wait_rank       = out_q.pos;
	assign free_credits    = out_q.free;
	assign last            = last_q;
	assign pready          = 1'b1;
	assign prdata          = (paddr[2] == REG_LIMIT) ? {27'd0, limit_q} : {27'd0, total_q};

endmodule

// ===== hw/rtl/cfjd_checker.sv =====
// Port-level checks of the job dispatcher, bound to the top level.
// Depends on cfjd_pkg and credit_fifo_job_dispatcher_macros.svh.
`include "credit_fifo_job_dispatcher_macros.svh"

module cfjd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       res_valid,
	input logic       last,
	input logic [3:0] event_res,
	input logic [4:0] wait_rank,
	input logic [4:0] free_credits
);
	import cfjd_pkg::*;

	`CFJD_ASSERT_NXT(a_take_busy, start && !busy, busy, "accepted item did not raise busy")
	`CFJD_ASSERT_IMP(a_last_idle, res_valid, last == !busy, "last result and busy disagree")
	`CFJD_ASSERT_NXT(a_no_gap, res_valid && !last, res_valid, "gap inside result burst")
	`CFJD_ASSERT_IMP(a_pos_queued, res_valid && wait_rank != 5'd0, event_res == EV_QUEUED && free_credits <= 5'(MAX_CREDITS), "bad queue place")

endmodule

bind credit_fifo_job_dispatcher cfjd_checker u_cfjd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.res_valid    (res_valid),
	.last         (last),
	.event_res    (event_res),
	.wait_rank    (wait_rank),
	.free_credits (free_credits)
);

// ===== verif/credit_fifo_job_dispatcher_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the credit FIFO job dispatcher: tracks queue, slots and pool,
// predicts each command's results and compares them. Depends on cfjd_pkg.
module credit_fifo_job_dispatcher_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] job_id,
	input  logic [7:0]  requested_credits,
	input  logic [1:0]  outcome,
	input  logic        res_valid,
	input  logic [3:0]  event_res,
	input  logic [31:0] job_ref,
	input  logic [4:0]  granted_credits,
	input  logic [4:0]  wait_rank,
	input  logic [4:0]  free_credits,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fails,
	output int          waiting_results,
	output int          results_seen
);
	import cfjd_pkg::*;

	typedef struct packed {
		res_t r;
		logic fin;
	} outcome_exp_t;

	// shadow of the dispatcher state
	logic [31:0] q_id[QUEUE_DEPTH];
	logic [4:0]  q_cr[QUEUE_DEPTH];
	int          q_n;
	logic [31:0] slot_id[MAX_CREDITS];
	logic [4:0]  slot_cr[MAX_CREDITS];
	logic        slot_busy[MAX_CREDITS];
	logic        slot_cxl[MAX_CREDITS];
	logic [4:0]  pool;
	logic [31:0] id_next;
	logic        closed;
	logic [4:0]  total_reg, limit_reg;

	res_t         burst[$];
	outcome_exp_t results_due[$];

	assign waiting_results = results_due.size();

	function automatic int pool_size();
		if (total_reg == 0) return 1;
		return (total_reg > MAX_CREDITS) ? MAX_CREDITS : int'(total_reg);
	endfunction

	function automatic int wait_cap();
		if (limit_reg == 0) return 1;
		return (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_reg);
	endfunction

	function automatic void note(logic [3:0] ev, logic [31:0] r, logic [4:0] c, logic [4:0] p);
		res_t x;
		x.ev = ev; x.ref_id = r; x.cred = c; x.pos = p; x.free = pool;
		burst.insert(burst.size(), x);
	endfunction

	function automatic void unqueue(int k);
		for (int i = k; i + 1 < q_n; i++) begin
			q_id[i] = q_id[i+1];
			q_cr[i] = q_cr[i+1];
		end
		q_n--;
	endfunction

	function automatic int slot_of(logic [31:0] id);
		for (int s = 0; s < MAX_CREDITS; s++)
			if (slot_busy[s] && slot_id[s] == id) return s;
		return -1;
	endfunction

	// head-of-line start loop
	function automatic void launch_heads();
		int s;
		while (!closed && q_n > 0 && q_cr[0] <= pool) begin
			s = -1;
			for (int k = 0; k < MAX_CREDITS; k++)
				if (!slot_busy[k] && s < 0) s = k;
			if (s < 0) break;
			pool -= q_cr[0];
			slot_busy[s] = 1; slot_cxl[s] = 0;
			slot_id[s] = q_id[0]; slot_cr[s] = q_cr[0];
			unqueue(0);
			note(EV_STARTING, slot_id[s], slot_cr[s], 0);
		end
	endfunction

	function automatic void predict_command(logic [1:0] o, logic [31:0] id, logic [7:0] rq,
			logic [1:0] oc);
		int c, s, sum;
		logic hit;
		logic [3:0] ev;
		outcome_exp_t ex;
		burst.delete();
		case (o)
			OP_SUBMIT: begin
				c = (rq == 0) ? 1 : int'(rq);
				if (c > pool_size()) c = pool_size();
				if (closed) note(EV_SHUTTING, 0, 5'(c), 0);
				else if (q_n >= wait_cap()) note(EV_FULL, 0, 5'(c), 0);
				else begin
					q_id[q_n] = id_next; q_cr[q_n] = 5'(c); q_n++;
					note(EV_QUEUED, id_next, 5'(c), 5'(q_n));
					id_next++;
					launch_heads();
				end
			end
			OP_CANCEL: begin
				hit = 0;
				for (int i = 0; i < q_n && !hit; i++)
					if (q_id[i] == id) begin
						c = q_cr[i];
						unqueue(i);
						note(EV_CANCELLED, id, 5'(c), 0);
						launch_heads();
						hit = 1;
					end
				if (!hit) begin
					s = slot_of(id);
					if (s >= 0) begin
						slot_cxl[s] = 1;
						note(EV_CANCELLING, id, slot_cr[s], 0);
					end else note(EV_NOT_FOUND, id, 0, 0);
				end
			end
			OP_COMPLETE: begin
				s = slot_of(id);
				if (s < 0) note(EV_NOT_FOUND, id, 0, 0);
				else begin
					if (oc == OUT_SUCCEEDED) ev = slot_cxl[s] ? EV_CANCELLED : EV_SUCCEEDED;
					else if (oc == OUT_CANCELLED) ev = EV_CANCELLED;
					else ev = EV_FAILED;
					slot_busy[s] = 0; slot_cxl[s] = 0;
					sum = int'(pool) + int'(slot_cr[s]);
					pool = 5'((sum > pool_size()) ? pool_size() : sum);
					note(ev, id, slot_cr[s], 0);
					launch_heads();
				end
			end
			default: begin
				if (!closed) begin
					closed = 1;
					for (int i = 0; i < q_n; i++) note(EV_CANCELLED, q_id[i], q_cr[i], 0);
					q_n = 0;
				end
			end
		endcase
		foreach (burst[i]) begin
			ex.r   = burst[i];
			ex.fin = (i == burst.size() - 1);
			results_due.insert(results_due.size(), ex);
		end
	endfunction

	function automatic void write_reg(logic [2:0] a, logic [31:0] d);
		int used;
		if (a == 3'(4 * REG_TOTAL)) begin
			total_reg = d[4:0];
			used = 0;
			for (int s = 0; s < MAX_CREDITS; s++) if (slot_busy[s]) used += slot_cr[s];
			pool = 5'((used >= pool_size()) ? 0 : pool_size() - used);
		end else if (a == 3'(4 * REG_LIMIT)) limit_reg = d[4:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_exp_t e;
		if (!arst_n) begin
			q_n = 0; id_next = 1; closed = 0;
			total_reg = TOTAL_RESET; limit_reg = LIMIT_RESET;
			pool = 5'(pool_size());
			for (int s = 0; s < MAX_CREDITS; s++) begin
				slot_busy[s] = 0; slot_cxl[s] = 0;
			end
			results_due.delete();
			fails = 0; results_seen = 0;
		end else begin
			if (res_valid) begin
				results_seen++;
				if (results_due.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected result ev=%0d ref=%0h", event_res, job_ref);
				end else begin
					e = results_due[0];
					results_due.delete(0);
					if (e.r.ev !== event_res || e.r.ref_id !== job_ref ||
							e.r.cred !== granted_credits || e.r.pos !== wait_rank ||
							e.r.free !== free_credits || e.fin !== last) begin
						fails++;
						if (fails <= 10)
							$display("mismatch exp ev=%0d ref=%0h cr=%0d pos=%0d free=%0d last=%0b | got ev=%0d ref=%0h cr=%0d pos=%0d free=%0d last=%0b",
								e.r.ev, e.r.ref_id, e.r.cred, e.r.pos, e.r.free, e.fin,
								event_res, job_ref, granted_credits, wait_rank,
								free_credits, last);
					end
				end
			end
			if (start && !busy) predict_command(op, job_id, requested_credits, outcome);
			if (psel && penable && pwrite && pready) write_reg(paddr, pwdata);
		end
	end

endmodule

// ===== verif/credit_fifo_job_dispatcher_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the credit FIFO job dispatcher: clock, reset, APB setup,
// directed and random commands. Depends on cfjd_pkg and the checker module.
module credit_fifo_job_dispatcher_tb;
	import cfjd_pkg::*;

	logic        clk, arst_n;
	logic        start, busy;
	logic [1:0]  op;
	logic [31:0] job_id;
	logic [7:0]  requested_credits;
	logic [1:0]  outcome;
	logic        res_valid, last;
	logic [3:0]  event_res;
	logic [31:0] job_ref;
	logic [4:0]  granted_credits, wait_rank, free_credits;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fails, waiting_results, results_seen;

	// ids the block reported, used to aim cancels and completions
	logic [31:0] queued_jobs[$];
	logic [31:0] started_jobs[$];
	int          idle_pct;
	int          commands;
	int          stall;

	credit_fifo_job_dispatcher dut (.*);
	credit_fifo_job_dispatcher_checker chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// watchdog: cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || res_valid || (psel && penable))
			stall <= 0;
		else
			stall <= stall + 1;
		if (stall > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// harvest ids from the result stream
	always @(posedge clk) begin
		if (res_valid && event_res == EV_QUEUED) begin
			queued_jobs.insert(queued_jobs.size(), job_ref);
			if (queued_jobs.size() > 32) queued_jobs.delete(0);
		end
		if (res_valid && event_res == EV_STARTING) begin
			started_jobs.insert(started_jobs.size(), job_ref);
			if (started_jobs.size() > 32) started_jobs.delete(0);
		end
	end

	// start stays high across back-to-back commands; only a gap lowers it
	task automatic issue(logic [1:0] o, logic [31:0] id, logic [7:0] rq, logic [1:0] oc);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o; job_id <= id; requested_credits <= rq; outcome <= oc;
		do @(posedge clk); while (busy);
		commands++;
	endtask

	// drain: shutdown on an empty queue yields nothing, so allow the full latency
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || waiting_results != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] a, logic [31:0] d);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_command(bit allow_shutdown);
		int k;
		logic [31:0] id;
		logic [7:0]  rq;
		k = $urandom_range(99);
		rq = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
		id = $urandom;
		if (k < 42) issue(OP_SUBMIT, id, rq, 2'($urandom_range(3)));
		else if (k < 72) begin
			if (started_jobs.size() > 0 && $urandom_range(9) != 0) begin
				k = $urandom_range(started_jobs.size() - 1);
				id = started_jobs[k];
				started_jobs.delete(k);
			end
			issue(OP_COMPLETE, id, rq, 2'($urandom_range(3)));
		end else if (k < 97 || !allow_shutdown) begin
			k = $urandom_range(9);
			if (k < 5 && queued_jobs.size() > 0)
				id = queued_jobs[$urandom_range(queued_jobs.size() - 1)];
			else if (k < 8 && started_jobs.size() > 0)
				id = started_jobs[$urandom_range(started_jobs.size() - 1)];
			issue(OP_CANCEL, id, rq, 2'($urandom_range(3)));
		end else issue(OP_SHUTDOWN, id, rq, 2'($urandom_range(3)));
	endtask

	initial begin
		int tot[6] = '{1, 16, 0, 31, 7, 3};
		int lim[6] = '{1, 16, 0, 31, 3, 5};
		arst_n = 1'b0;
		start = 1'b0; op = OP_SUBMIT; job_id = '0; requested_credits = '0; outcome = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		idle_pct = 0; commands = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pool of 4 from reset, ids count up from 1
		issue(OP_SUBMIT, 0, 8'd0, 0);          // zero request -> one credit, starts
		issue(OP_SUBMIT, 0, 8'd1, 0);
		issue(OP_SUBMIT, 0, 8'd255, 0);        // clamped to pool, head blocks
		issue(OP_SUBMIT, 0, 8'd16, 0);
		issue(OP_SUBMIT, 0, 8'd17, 0);
		issue(OP_CANCEL, 32'd4, 0, 0);         // waiting job removed
		issue(OP_CANCEL, 32'd1, 0, 0);         // running job flagged
		issue(OP_CANCEL, 32'd1, 0, 0);         // flagged again
		issue(OP_COMPLETE, 32'd1, 0, OUT_SUCCEEDED);  // success after cancel request
		issue(OP_COMPLETE, 32'd2, 0, 2'd3);    // outcome 3 counts as failed
		issue(OP_COMPLETE, 32'd3, 0, OUT_CANCELLED);
		issue(OP_COMPLETE, 32'd5, 0, 2'd1);
		issue(OP_COMPLETE, 32'd0, 8'hFF, 0);   // unknown id
		issue(OP_CANCEL, 32'hFFFF_FFFF, 0, 0); // unknown id
		issue(OP_SUBMIT, 0, 8'd2, 0);
		issue(OP_COMPLETE, 32'd6, 0, OUT_SUCCEEDED);
		settle();

		// random phases, each under its own register setting and one of three idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(3'(4 * REG_TOTAL), 32'(tot[ph]));
			apb_write(3'(4 * REG_LIMIT), 32'(lim[ph]));
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 69;
				default: idle_pct = 35;
			endcase
			for (int n = 0; n < 40; n++) begin
				idle_pct = (n >= 30 && ph % 3 != 0) ? 0 : idle_pct;
				random_command(ph == 5 && n > 25);
			end
			settle();
		end

		// shutdown drains the queue; afterwards submits are refused
		apb_write(3'(4 * REG_LIMIT), 32'd16);
		idle_pct = 0;
		for (int n = 0; n < 12; n++) issue(OP_SUBMIT, 0, 8'($urandom_range(20)), 0);
		issue(OP_SHUTDOWN, 0, 0, 0);
		issue(OP_SHUTDOWN, 0, 0, 0);
		for (int n = 0; n < 10; n++) random_command(1'b0);

		start <= 1'b0;
		@(posedge clk);
		while (busy || waiting_results != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d commands and checked %0d results over seven register settings,",
			commands, results_seen);
		$display("with sender gaps, blocked heads, cancels, completions and shutdown.");
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== credit_fifo_job_dispatcher.f =====
+incdir+hw/rtl
hw/rtl/cfjd_pkg.sv
hw/rtl/cfjd_wait_cell.sv
hw/rtl/cfjd_run_cell.sv
hw/rtl/credit_fifo_job_dispatcher.sv
hw/rtl/cfjd_checker.sv
verif/credit_fifo_job_dispatcher_checker.sv
verif/credit_fifo_job_dispatcher_tb.sv
